// File: sv/cvp_pkg.sv
// Shared constants, types and saturation helpers of the cavity velocity predictor.
package cvp_pkg;

	localparam int COL_W     = 10;
	localparam int ROW_W     = 10;
	localparam int MAX_WIDTH = 1 << COL_W;
	localparam int MAX_HEIGHT = 1 << ROW_W;
	localparam int DIM_W     = 11;
	localparam int FRAC_BITS = 20;
	localparam int ADDR_W    = COL_W + 1;
	localparam int RAM_DEPTH = 2 * MAX_WIDTH;
	localparam int PADDR_W   = 5;
	localparam int N_STEPS   = 18;
	localparam int STEP_W    = 5;
	localparam int ACC_W     = 35;

	typedef enum logic [2:0] {
		REG_WIDTH,
		REG_HEIGHT,
		REG_ADV_X,
		REG_ADV_Y,
		REG_DIFF_X,
		REG_DIFF_Y,
		REG_LID
	} reg_idx_t;

	typedef struct packed {
		logic signed [31:0] u_in;
		logic signed [31:0] v_in;
		logic signed [31:0] p_in;
	} cell_t;

	typedef struct packed {
		logic [COL_W-1:0]   col_index;
		logic [ROW_W-1:0]   row_index;
		logic signed [31:0] u_new;
		logic signed [31:0] v_new;
		logic               last_of_grid;
	} res_t;

	typedef struct packed {
		logic [DIM_W-1:0]   grid_width;
		logic [DIM_W-1:0]   grid_height;
		logic [30:0]        adv_x_coef;
		logic [30:0]        adv_y_coef;
		logic [30:0]        diff_x_coef;
		logic [30:0]        diff_y_coef;
		logic signed [31:0] lid_speed;
	} cfg_t;

	typedef struct packed {
		cell_t            data;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic             has_prev;
		logic             interior;
		logic             last_row;
		logic             last_grid;
	} job_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_READ,
		BK_MUL,
		BK_WRITE,
		BK_EMIT
	} back_state_t;

	function automatic logic signed [31:0] sat33(input logic signed [32:0] x);
		if (x[32] != x[31])
			return x[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		return x[31:0];
	endfunction

	function automatic logic signed [31:0] sat35(input logic signed [ACC_W-1:0] x);
		if (x[ACC_W-1:31] != {(ACC_W-31){x[ACC_W-1]}})
			return x[ACC_W-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		return x[31:0];
	endfunction

	function automatic logic signed [31:0] sub_sat(input logic signed [31:0] a,
		input logic signed [31:0] b);
		logic signed [32:0] d;
		d = {a[31], a} - {b[31], b};
		return sat33(d);
	endfunction

	// sat(sat(a-c) + sat(b-c)): the diffusion stencil
	function automatic logic signed [31:0] diff2(input logic signed [31:0] a,
		input logic signed [31:0] b, input logic signed [31:0] c);
		logic signed [31:0] d1;
		logic signed [31:0] d2;
		d1 = sub_sat(a, c);
		d2 = sub_sat(b, c);
		return sat33({d1[31], d1} + {d2[31], d2});
	endfunction

	// floor(p / 2^FRAC_BITS), saturated
	function automatic logic signed [31:0] fx_scale(input logic signed [63:0] p);
		logic signed [63:0] q;
		q = p >>> FRAC_BITS;
		if (q[63:31] != {33{q[63]}})
			return q[63] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		return q[31:0];
	endfunction

endpackage

// File: sv/cvp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cvp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

// File: sv/cvp_front.sv
// Front end: cell acceptance, raster position tracking and classification.
module cvp_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cell_valid,
	output logic                 cell_ready,
	input  cvp_pkg::cell_t       cell_data,
	input  cvp_pkg::cfg_t        cfg,
	output logic                 job_valid,
	input  logic                 job_ready,
	output cvp_pkg::job_t        job
);

	logic [cvp_pkg::COL_W-1:0] col_q;
	logic [cvp_pkg::ROW_W-1:0] row_q;
	logic [cvp_pkg::DIM_W-1:0] w_eff;
	logic [cvp_pkg::DIM_W-1:0] h_eff;
	logic [cvp_pkg::COL_W-1:0] c;
	logic [cvp_pkg::ROW_W-1:0] r;
	logic [cvp_pkg::DIM_W-1:0] c1;
	logic [cvp_pkg::DIM_W-1:0] r1;
	logic                      take;

	always_comb begin
		w_eff = cfg.grid_width;
		if (cfg.grid_width < cvp_pkg::DIM_W'(3))
			w_eff = cvp_pkg::DIM_W'(3);
		else if (cfg.grid_width > cvp_pkg::DIM_W'(cvp_pkg::MAX_WIDTH))
			w_eff = cvp_pkg::DIM_W'(cvp_pkg::MAX_WIDTH);
		h_eff = cfg.grid_height;
		if (cfg.grid_height < cvp_pkg::DIM_W'(3))
			h_eff = cvp_pkg::DIM_W'(3);
		else if (cfg.grid_height > cvp_pkg::DIM_W'(cvp_pkg::MAX_HEIGHT))
			h_eff = cvp_pkg::DIM_W'(cvp_pkg::MAX_HEIGHT);

		// restart a counter that lies outside the grid
		c = ({1'b0, col_q} >= w_eff) ? '0 : col_q;
		r = ({1'b0, row_q} >= h_eff) ? '0 : row_q;
		c1 = {1'b0, c} + cvp_pkg::DIM_W'(1);
		r1 = {1'b0, r} + cvp_pkg::DIM_W'(1);

		job.data      = cell_data;
		job.col       = c;
		job.row       = r;
		job.has_prev  = (r != '0);
		job.interior  = (r >= cvp_pkg::ROW_W'(2)) && (c != '0) &&
			(c1 + cvp_pkg::DIM_W'(1) <= w_eff);
		job.last_row  = (r1 == h_eff);
		job.last_grid = (r1 == h_eff) && (c1 == w_eff);
	end

	assign job_valid  = cell_valid;
	assign cell_ready = job_ready;
	assign take       = cell_valid && job_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (take) begin
			if (c1 >= w_eff) begin
				col_q <= '0;
				row_q <= (r1 >= h_eff) ? '0 : r1[cvp_pkg::ROW_W-1:0];
			end else begin
				col_q <= c1[cvp_pkg::COL_W-1:0];
				row_q <= r;
			end
		end
	end

endmodule

// File: sv/cvp_queue.sv
// Two-entry queue between front and back ends.
module cvp_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  cvp_pkg::job_t  push_data,
	output logic           pop_valid,
	input  logic           pop_ready,
	output cvp_pkg::job_t  pop_data
);

	cvp_pkg::job_t ent_q [2];
	logic          wptr_q;
	logic          rptr_q;
	logic [1:0]    cnt_q;
	logic          push;
	logic          pop;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid  = (cnt_q != 2'd0);
	assign pop_data   = ent_q[rptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push)
			ent_q[wptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push)
				wptr_q <= ~wptr_q;
			if (pop)
				rptr_q <= ~rptr_q;
			if (push && !pop)
				cnt_q <= cnt_q + 2'd1;
			else if (pop && !push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

endmodule

// File: sv/cvp_back.sv
// Back end: line store, stencil reads, shared multiplier sequence, result output.
module cvp_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           job_valid,
	output logic           job_ready,
	input  cvp_pkg::job_t  job,
	input  cvp_pkg::cfg_t  cfg,
	output logic           res_valid,
	input  logic           res_ready,
	output cvp_pkg::res_t  res
);

	cvp_pkg::back_state_t       state_q, state_d;
	cvp_pkg::job_t              job_q;
	cvp_pkg::cell_t             prv_w_q, prv_c_q, prv_e_q, cur_c_q;
	logic [2:0]                 rd_cnt_q;
	logic [cvp_pkg::STEP_W-1:0] step_q;
	logic [cvp_pkg::STEP_W-1:0] wb_step;
	logic signed [31:0]         mr_q [8];
	logic signed [cvp_pkg::ACC_W-1:0] acc_u_q, acc_v_q;
	logic signed [63:0]         prod_s1;
	logic signed [31:0]         a_op, b_op, term;
	logic                       emit_idx_q;
	cvp_pkg::res_t              out_q, out_d;
	logic                       out_valid_q;
	logic                       out_free, load;

	logic                       ram_we, ram_re;
	logic [cvp_pkg::ADDR_W-1:0] ram_waddr, ram_raddr;
	cvp_pkg::cell_t             ram_rdata;

	logic signed [31:0] uc, ue, uw, us, un, vc, ve, vw, vs, vn, pe, pw, ps, pn;
	logic signed [31:0] ax, ay, dx, dy;

	cvp_ram #(
		.WIDTH($bits(cvp_pkg::cell_t)),
		.DEPTH(cvp_pkg::RAM_DEPTH)
	) u_lines (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(job_q.data),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign uc = prv_c_q.u_in;  assign vc = prv_c_q.v_in;
	assign ue = prv_e_q.u_in;  assign ve = prv_e_q.v_in;  assign pe = prv_e_q.p_in;
	assign uw = prv_w_q.u_in;  assign vw = prv_w_q.v_in;  assign pw = prv_w_q.p_in;
	assign us = cur_c_q.u_in;  assign vs = cur_c_q.v_in;  assign ps = cur_c_q.p_in;
	assign un = job_q.data.u_in; assign vn = job_q.data.v_in; assign pn = job_q.data.p_in;
	assign ax = $signed({1'b0, cfg.adv_x_coef});
	assign ay = $signed({1'b0, cfg.adv_y_coef});
	assign dx = $signed({1'b0, cfg.diff_x_coef});
	assign dy = $signed({1'b0, cfg.diff_y_coef});

	// line store addressing: previous row in the other bank
	always_comb begin
		ram_re    = (state_q == cvp_pkg::BK_READ) && (rd_cnt_q < 3'd4);
		ram_we    = (state_q == cvp_pkg::BK_WRITE);
		ram_waddr = {job_q.row[0], job_q.col};
		case (rd_cnt_q)
			3'd0:    ram_raddr = {~job_q.row[0], job_q.col - cvp_pkg::COL_W'(1)};
			3'd1:    ram_raddr = {~job_q.row[0], job_q.col};
			3'd2:    ram_raddr = {~job_q.row[0], job_q.col + cvp_pkg::COL_W'(1)};
			default: ram_raddr = {job_q.row[0], job_q.col};
		endcase
	end

	// operand sequence of the shared multiplier
	always_comb begin
		case (step_q)
			5'd0:    begin a_op = ue; b_op = ue; end
			5'd1:    begin a_op = uw; b_op = uw; end
			5'd2:    begin a_op = un; b_op = vn; end
			5'd3:    begin a_op = us; b_op = vs; end
			5'd4:    begin a_op = vn; b_op = vn; end
			5'd5:    begin a_op = vs; b_op = vs; end
			5'd6:    begin a_op = ue; b_op = ve; end
			5'd7:    begin a_op = uw; b_op = vw; end
			5'd8:    begin a_op = ax; b_op = cvp_pkg::sub_sat(mr_q[0], mr_q[1]); end
			5'd9:    begin a_op = ay; b_op = cvp_pkg::sub_sat(mr_q[2], mr_q[3]); end
			5'd10:   begin a_op = ax; b_op = cvp_pkg::sub_sat(pe, pw); end
			5'd11:   begin a_op = dx; b_op = cvp_pkg::diff2(ue, uw, uc); end
			5'd12:   begin a_op = dy; b_op = cvp_pkg::diff2(un, us, uc); end
			5'd13:   begin a_op = ay; b_op = cvp_pkg::sub_sat(mr_q[4], mr_q[5]); end
			5'd14:   begin a_op = ax; b_op = cvp_pkg::sub_sat(mr_q[6], mr_q[7]); end
			5'd15:   begin a_op = ay; b_op = cvp_pkg::sub_sat(pn, ps); end
			5'd16:   begin a_op = dx; b_op = cvp_pkg::diff2(ve, vw, vc); end
			5'd17:   begin a_op = dy; b_op = cvp_pkg::diff2(vn, vs, vc); end
			default: begin a_op = '0; b_op = '0; end
		endcase
	end

	assign wb_step = step_q - cvp_pkg::STEP_W'(1);
	assign term    = cvp_pkg::fx_scale(prod_s1);

	always_comb begin
		out_d = '0;
		out_d.col_index = job_q.col;
		if (!emit_idx_q) begin
			out_d.row_index = job_q.row - cvp_pkg::ROW_W'(1);
			out_d.u_new = job_q.interior ? cvp_pkg::sat35(acc_u_q) : '0;
			out_d.v_new = job_q.interior ? cvp_pkg::sat35(acc_v_q) : '0;
		end else begin
			out_d.row_index    = job_q.row;
			out_d.u_new        = cfg.lid_speed;
			out_d.last_of_grid = job_q.last_grid;
		end
	end

	assign out_free  = !out_valid_q || res_ready;
	assign load      = (state_q == cvp_pkg::BK_EMIT) && out_free;
	assign job_ready = (state_q == cvp_pkg::BK_IDLE);
	assign res_valid = out_valid_q;
	assign res       = out_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			cvp_pkg::BK_IDLE:
				if (job_valid)
					state_d = job.interior ? cvp_pkg::BK_READ : cvp_pkg::BK_WRITE;
			cvp_pkg::BK_READ:
				if (rd_cnt_q == 3'd4)
					state_d = cvp_pkg::BK_MUL;
			cvp_pkg::BK_MUL:
				if (step_q == cvp_pkg::STEP_W'(cvp_pkg::N_STEPS))
					state_d = cvp_pkg::BK_WRITE;
			cvp_pkg::BK_WRITE:
				if (job_q.has_prev || job_q.last_row)
					state_d = cvp_pkg::BK_EMIT;
				else
					state_d = cvp_pkg::BK_IDLE;
			cvp_pkg::BK_EMIT:
				if (load && (emit_idx_q || !job_q.last_row))
					state_d = cvp_pkg::BK_IDLE;
			default:
				state_d = cvp_pkg::BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cvp_pkg::BK_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load)
				out_valid_q <= 1'b1;
			else if (res_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= a_op * b_op;
		if (load)
			out_q <= out_d;
		case (state_q)
			cvp_pkg::BK_IDLE: begin
				job_q    <= job;
				rd_cnt_q <= '0;
			end
			cvp_pkg::BK_READ: begin
				rd_cnt_q <= rd_cnt_q + 3'd1;
				case (rd_cnt_q)
					3'd1:    prv_w_q <= ram_rdata;
					3'd2:    prv_c_q <= ram_rdata;
					3'd3:    prv_e_q <= ram_rdata;
					3'd4:    cur_c_q <= ram_rdata;
					default: ;
				endcase
				step_q  <= '0;
				acc_u_q <= cvp_pkg::ACC_W'(prv_c_q.u_in);
				acc_v_q <= cvp_pkg::ACC_W'(prv_c_q.v_in);
			end
			cvp_pkg::BK_MUL: begin
				step_q <= step_q + cvp_pkg::STEP_W'(1);
				// write back the product issued last cycle
				if (step_q != '0) begin
					if (wb_step < cvp_pkg::STEP_W'(8))
						mr_q[wb_step[2:0]] <= term;
					else if (wb_step <= cvp_pkg::STEP_W'(10))
						acc_u_q <= acc_u_q - cvp_pkg::ACC_W'(term);
					else if (wb_step <= cvp_pkg::STEP_W'(12))
						acc_u_q <= acc_u_q + cvp_pkg::ACC_W'(term);
					else if (wb_step <= cvp_pkg::STEP_W'(15))
						acc_v_q <= acc_v_q - cvp_pkg::ACC_W'(term);
					else
						acc_v_q <= acc_v_q + cvp_pkg::ACC_W'(term);
				end
			end
			cvp_pkg::BK_WRITE:
				emit_idx_q <= !job_q.has_prev;
			cvp_pkg::BK_EMIT:
				if (load)
					emit_idx_q <= 1'b1;
			default: ;
		endcase
	end

endmodule

// File: sv/cavity_velocity_predictor_stencil.sv
// Top level of the cavity velocity predictor: register file and front/back ends.
//
//  channel  | signals                                   | transaction
//  ---------+-------------------------------------------+---------------------------
//  cell     | cell_valid, cell_ready, cell_data (u,v,p) | one grid cell, raster order
//  res      | res_valid, res_ready, res                 | one predicted cell
//  apb      | psel, penable, pwrite, paddr, pwdata, ... | one register access
//
// Sequence: an interior cell holds the back end through accept, four line store reads,
// eighteen products through the one shared 32x32 multiplier, write and emit, with a
// second emit on the last row; a wall cell goes from accept to write, then emit, with
// no emit on the first row and two on the last. The single multiplier sets the rate.
// Reset clears the position counters, queue and state; the line store is
// not cleared. Either side may stall: the two-entry queue and the output
// register decouple the cell and result channels.
module cavity_velocity_predictor_stencil (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cell_valid,
	output logic                        cell_ready,
	input  cvp_pkg::cell_t              cell_data,
	output logic                        res_valid,
	input  logic                        res_ready,
	output cvp_pkg::res_t               res,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [cvp_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	cvp_pkg::cfg_t    cfg_q;
	cvp_pkg::reg_idx_t reg_idx;
	logic             wr_en;
	logic             fq_valid, fq_ready, qb_valid, qb_ready;
	cvp_pkg::job_t    fq_job, qb_job;

	assign pready  = 1'b1;
	assign reg_idx = cvp_pkg::reg_idx_t'(paddr[4:2]);
	assign wr_en   = psel && penable && pwrite;

	// register write: access phase of a write transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.grid_width  <= cvp_pkg::DIM_W'(128);
			cfg_q.grid_height <= cvp_pkg::DIM_W'(128);
			cfg_q.adv_x_coef  <= '0;
			cfg_q.adv_y_coef  <= '0;
			cfg_q.diff_x_coef <= '0;
			cfg_q.diff_y_coef <= '0;
			cfg_q.lid_speed   <= 32'sd1048576;
		end else if (wr_en) begin
			case (reg_idx)
				cvp_pkg::REG_WIDTH:  cfg_q.grid_width  <= pwdata[10:0];
				cvp_pkg::REG_HEIGHT: cfg_q.grid_height <= pwdata[10:0];
				cvp_pkg::REG_ADV_X:  cfg_q.adv_x_coef  <= pwdata[30:0];
				cvp_pkg::REG_ADV_Y:  cfg_q.adv_y_coef  <= pwdata[30:0];
				cvp_pkg::REG_DIFF_X: cfg_q.diff_x_coef <= pwdata[30:0];
				cvp_pkg::REG_DIFF_Y: cfg_q.diff_y_coef <= pwdata[30:0];
				cvp_pkg::REG_LID:    cfg_q.lid_speed   <= pwdata;
				default: ;
			endcase
		end
	end

	// register read-back
	always_comb begin
		case (reg_idx)
			cvp_pkg::REG_WIDTH:  prdata = {21'd0, cfg_q.grid_width};
			cvp_pkg::REG_HEIGHT: prdata = {21'd0, cfg_q.grid_height};
			cvp_pkg::REG_ADV_X:  prdata = {1'b0, cfg_q.adv_x_coef};
			cvp_pkg::REG_ADV_Y:  prdata = {1'b0, cfg_q.adv_y_coef};
			cvp_pkg::REG_DIFF_X: prdata = {1'b0, cfg_q.diff_x_coef};
			cvp_pkg::REG_DIFF_Y: prdata = {1'b0, cfg_q.diff_y_coef};
			cvp_pkg::REG_LID:    prdata = cfg_q.lid_speed;
			default:             prdata = '0;
		endcase
	end

	// front: track raster position and classify each cell
	cvp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cell_valid(cell_valid),
		.cell_ready(cell_ready),
		.cell_data (cell_data),
		.cfg       (cfg_q),
		.job_valid (fq_valid),
		.job_ready (fq_ready),
		.job       (fq_job)
	);

	// hold classified cells while the back end is busy
	cvp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(fq_valid),
		.push_ready(fq_ready),
		.push_data (fq_job),
		.pop_valid (qb_valid),
		.pop_ready (qb_ready),
		.pop_data  (qb_job)
	);

	// back: stencil arithmetic and result delivery
	cvp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.job_valid(qb_valid),
		.job_ready(qb_ready),
		.job      (qb_job),
		.cfg      (cfg_q),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

endmodule

// File: test/tb_cavity_velocity_predictor_stencil.sv
// Testbench of the cavity velocity predictor: directed table, random grids, scoreboard.
module tb_cavity_velocity_predictor_stencil;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int  DRAIN_CYCLES = 60;        // margin for an interior cell plus queue and output
	localparam int  CYCLE_LIMIT  = 1_500_000;
	localparam int  RANDOM_ITEMS = 400;
	localparam int  BANK         = cvp_pkg::MAX_WIDTH;

	// One row of the directed table: a cell, and the results it must cause when they can be
	// read off by eye. typed_n < 0 leaves the results to the predictor.
	typedef struct {
		cvp_pkg::cell_t c;
		int             typed_n;
		cvp_pkg::res_t  r0;
		cvp_pkg::res_t  r1;
	} dir_row_t;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  cell_valid = 1'b0;
	logic  cell_ready;
	cvp_pkg::cell_t cell_data = '0;
	logic  res_valid;
	logic  res_ready = 1'b0;
	cvp_pkg::res_t res;
	logic  psel = 1'b0;
	logic  penable = 1'b0;
	logic  pwrite = 1'b0;
	logic [cvp_pkg::PADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic  pready;

	cavity_velocity_predictor_stencil i_dut (
		.clk, .arst_n, .cell_valid, .cell_ready, .cell_data, .res_valid, .res_ready, .res,
		.psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
	);

	always #5 clk = ~clk;

	// Predictor state: register shadow, line stores and raster position.
	cvp_pkg::cfg_t      cfg_shadow;
	logic signed [31:0] store_u [0:2*BANK-1];
	logic signed [31:0] store_v [0:2*BANK-1];
	logic signed [31:0] store_p [0:2*BANK-1];
	int                 col_pos, row_pos;
	cvp_pkg::res_t      pending_res[$];
	int                 fail_cnt = 0;
	int                 cycle_cnt = 0;
	bit                 quiet = 1'b0;   // no idling on either side while set
	int                 fed = 0;

	function automatic longint clip32(longint x);
		if (x > 64'sd2147483647) return 64'sd2147483647;
		if (x < -64'sd2147483648) return -64'sd2147483648;
		return x;
	endfunction

	// Fixed-point product: floor toward minus infinity, then saturate.
	function automatic longint mulfx(longint a, longint b);
		longint p;
		p = a * b;
		return clip32(p >>> cvp_pkg::FRAC_BITS);
	endfunction

	function automatic longint subc(longint a, longint b);
		return clip32(a - b);
	endfunction

	function automatic int clampdim(logic [cvp_pkg::DIM_W-1:0] v, int hi);
		if (v < 3) return 3;
		if (v > hi) return hi;
		return int'(v);
	endfunction

	function automatic void push_res(int c, int r, longint un, longint vn, bit last);
		cvp_pkg::res_t e;
		e.col_index    = c[cvp_pkg::COL_W-1:0];
		e.row_index    = r[cvp_pkg::ROW_W-1:0];
		e.u_new        = un[31:0];
		e.v_new        = vn[31:0];
		e.last_of_grid = last;
		pending_res.push_back(e);
	endfunction

	// Advance the predictor by one accepted cell; queue its results when asked.
	function automatic void predict_velocity(cvp_pkg::cell_t c, bit keep);
		int     w, h, cur, prv, rr;
		longint ax, ay, dx, dy, un, vn, s;
		longint uc, ue, uw, us, vc, ve, vw, vs, pe, pw, ps, unn, vnn, pnn;
		w  = clampdim(cfg_shadow.grid_width, cvp_pkg::MAX_WIDTH);
		h  = clampdim(cfg_shadow.grid_height, cvp_pkg::MAX_HEIGHT);
		ax = longint'(cfg_shadow.adv_x_coef);
		ay = longint'(cfg_shadow.adv_y_coef);
		dx = longint'(cfg_shadow.diff_x_coef);
		dy = longint'(cfg_shadow.diff_y_coef);
		// restart any counter that a resize left outside the grid
		if (col_pos >= w) col_pos = 0;
		if (row_pos >= h) row_pos = 0;
		cur = (row_pos & 1) * BANK;
		if (row_pos >= 1) begin
			rr = row_pos - 1;
			prv = (rr & 1) * BANK;
			un = 0;
			vn = 0;
			if (rr >= 1 && rr + 2 <= h && col_pos >= 1 && col_pos + 2 <= w) begin
				uc = longint'(store_u[prv+col_pos]);   ue = longint'(store_u[prv+col_pos+1]);
				uw = longint'(store_u[prv+col_pos-1]); us = longint'(store_u[cur+col_pos]);
				vc = longint'(store_v[prv+col_pos]);   ve = longint'(store_v[prv+col_pos+1]);
				vw = longint'(store_v[prv+col_pos-1]); vs = longint'(store_v[cur+col_pos]);
				pe = longint'(store_p[prv+col_pos+1]); pw = longint'(store_p[prv+col_pos-1]);
				ps = longint'(store_p[cur+col_pos]);
				unn = longint'(c.u_in); vnn = longint'(c.v_in); pnn = longint'(c.p_in);
				s = uc;
				s -= mulfx(ax, subc(mulfx(ue, ue), mulfx(uw, uw)));
				s -= mulfx(ay, subc(mulfx(unn, vnn), mulfx(us, vs)));
				s -= mulfx(ax, subc(pe, pw));
				s += mulfx(dx, clip32(subc(ue, uc) + subc(uw, uc)));
				s += mulfx(dy, clip32(subc(unn, uc) + subc(us, uc)));
				un = clip32(s);
				s = vc;
				s -= mulfx(ay, subc(mulfx(vnn, vnn), mulfx(vs, vs)));
				s -= mulfx(ax, subc(mulfx(ue, ve), mulfx(uw, vw)));
				s -= mulfx(ay, subc(pnn, ps));
				s += mulfx(dx, clip32(subc(ve, vc) + subc(vw, vc)));
				s += mulfx(dy, clip32(subc(vnn, vc) + subc(vs, vc)));
				vn = clip32(s);
			end
			if (keep) push_res(col_pos, rr, un, vn, 1'b0);
		end
		store_u[cur+col_pos] = c.u_in;
		store_v[cur+col_pos] = c.v_in;
		store_p[cur+col_pos] = c.p_in;
		if (keep && row_pos + 1 == h)
			push_res(col_pos, row_pos, longint'(cfg_shadow.lid_speed), 0, col_pos + 1 == w);
		col_pos++;
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos++;
			if (row_pos >= h) row_pos = 0;
		end
	endfunction

	// Register write: setup phase, then access phase. Call and return at a rising edge.
	task automatic write_reg(cvp_pkg::reg_idx_t idx, logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			cvp_pkg::REG_WIDTH:  cfg_shadow.grid_width  = val[cvp_pkg::DIM_W-1:0];
			cvp_pkg::REG_HEIGHT: cfg_shadow.grid_height = val[cvp_pkg::DIM_W-1:0];
			cvp_pkg::REG_ADV_X:  cfg_shadow.adv_x_coef  = val[30:0];
			cvp_pkg::REG_ADV_Y:  cfg_shadow.adv_y_coef  = val[30:0];
			cvp_pkg::REG_DIFF_X: cfg_shadow.diff_x_coef = val[30:0];
			cvp_pkg::REG_DIFF_Y: cfg_shadow.diff_y_coef = val[30:0];
			cvp_pkg::REG_LID:    cfg_shadow.lid_speed   = val;
			default: ;
		endcase
	endtask

	task automatic write_all(logic [31:0] w, logic [31:0] h, logic [31:0] ax, logic [31:0] ay,
		logic [31:0] dx, logic [31:0] dy, logic [31:0] lid);
		write_reg(cvp_pkg::REG_WIDTH, w);
		write_reg(cvp_pkg::REG_HEIGHT, h);
		write_reg(cvp_pkg::REG_ADV_X, ax);
		write_reg(cvp_pkg::REG_ADV_Y, ay);
		write_reg(cvp_pkg::REG_DIFF_X, dx);
		write_reg(cvp_pkg::REG_DIFF_Y, dy);
		write_reg(cvp_pkg::REG_LID, lid);
	endtask

	// Offer one cell and hold it until the transaction completes. A random idle gap may
	// come first; valid is dropped only then, so it never toggles within one step.
	task automatic feed_cell(cvp_pkg::cell_t c, int typed_n = -1, cvp_pkg::res_t t0 = '0,
		cvp_pkg::res_t t1 = '0);
		if (!quiet && $urandom_range(99) < 9) begin
			cell_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		cell_valid <= 1'b1;
		cell_data  <= c;
		do @(posedge clk); while (!cell_ready);
		predict_velocity(c, typed_n < 0);
		if (typed_n > 0) pending_res.push_back(t0);
		if (typed_n > 1) pending_res.push_back(t1);
		fed++;
	endtask

	// Hold off the sender until every expected transaction is back, then let the
	// back end settle so a register write finds it idle.
	task automatic drain();
		cell_valid <= 1'b0;
		while (pending_res.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_val(bit full);
		if (full) return $urandom;
		return $urandom_range(0, 1 << 23) - (1 << 22);
	endfunction

	function automatic logic [31:0] rand_coef();
		case ($urandom_range(5))
			0:       return 32'd0;
			1:       return 32'h7fff_ffff;
			2:       return $urandom;
			default: return $urandom_range(0, 1 << 19);
		endcase
	endfunction

	// Receiver: stall about 9 percent of the time unless a quiet stretch is on.
	always @(posedge clk)
		res_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 9);

	// Scoreboard: each result transaction against the oldest expectation, field by field.
	always @(posedge clk) begin
		cvp_pkg::res_t e;
		if (arst_n && res_valid && res_ready) begin
			if (pending_res.size() == 0) begin
				fail_cnt++;
				$display("%0t: unexpected result %p", $time, res);
			end else begin
				e = pending_res.pop_front();
				if (res.col_index !== e.col_index) begin
					fail_cnt++;
					$display("%0t: col_index exp %0d got %0d", $time, e.col_index, res.col_index);
				end
				if (res.row_index !== e.row_index) begin
					fail_cnt++;
					$display("%0t: row_index exp %0d got %0d", $time, e.row_index, res.row_index);
				end
				if (res.u_new !== e.u_new) begin
					fail_cnt++;
					$display("%0t: u_new exp %h got %h", $time, e.u_new, res.u_new);
				end
				if (res.v_new !== e.v_new) begin
					fail_cnt++;
					$display("%0t: v_new exp %h got %h", $time, e.v_new, res.v_new);
				end
				if (res.last_of_grid !== e.last_of_grid) begin
					fail_cnt++;
					$display("%0t: last_of_grid exp %b got %b", $time, e.last_of_grid,
						res.last_of_grid);
				end
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	localparam logic signed [31:0] MAXV = 32'sh7fff_ffff;
	localparam logic signed [31:0] MINV = 32'sh8000_0000;

	// Directed grids. First 3x3 (width written 0, height 1: both act as 3), all coefficients
	// at their top and lid at the most negative value: the one interior cell saturates.
	// Then 3x4 with zero coefficients and lid at its top. Walls and the first row are typed in.
	dir_row_t dir_tab [0:20] = '{
		'{'{MAXV, MINV, MAXV}, 0, '0, '0},
		'{'{MINV, MAXV, MINV}, 0, '0, '0},
		'{'{32'sd0, 32'sd0, 32'sd0}, 0, '0, '0},
		'{'{MINV, MAXV, MAXV}, 1, '{0, 0, 0, 0, 0}, '0},
		'{'{MAXV, MINV, MINV}, 1, '{1, 0, 0, 0, 0}, '0},
		'{'{MINV, MINV, MAXV}, 1, '{2, 0, 0, 0, 0}, '0},
		'{'{32'sd1, -32'sd1, 32'sd5}, 2, '{0, 1, 0, 0, 0}, '{0, 2, MINV, 0, 0}},
		'{'{MAXV, MAXV, MINV}, -1, '0, '0},
		'{'{-32'sd1, 32'sd1, 32'sd0}, 2, '{2, 1, 0, 0, 0}, '{2, 2, MINV, 0, 1}},
		'{'{32'sd100, 32'sd200, 32'sd300}, 0, '0, '0},
		'{'{32'sd4, 32'sd5, 32'sd6}, 0, '0, '0},
		'{'{-32'sd7, 32'sd8, 32'sd9}, 0, '0, '0},
		'{'{32'sd1048576, -32'sd1048576, 32'sd0}, 1, '{0, 0, 0, 0, 0}, '0},
		'{'{32'sd2097152, 32'sd524288, 32'sd12345}, 1, '{1, 0, 0, 0, 0}, '0},
		'{'{-32'sd3, MAXV, MINV}, 1, '{2, 0, 0, 0, 0}, '0},
		'{'{32'sd11, 32'sd12, 32'sd13}, 1, '{0, 1, 0, 0, 0}, '0},
		'{'{MINV, MINV, MINV}, -1, '0, '0},
		'{'{32'sd21, 32'sd22, 32'sd23}, 1, '{2, 1, 0, 0, 0}, '0},
		'{'{32'sd31, 32'sd32, 32'sd33}, 2, '{0, 2, 0, 0, 0}, '{0, 3, MAXV, 0, 0}},
		'{'{MAXV, MAXV, MAXV}, -1, '0, '0},
		'{'{32'sd51, 32'sd52, 32'sd53}, 2, '{2, 2, 0, 0, 0}, '{2, 3, MAXV, 0, 1}}
	};

	initial begin
		int    w, h, n, phase;
		bit    full;
		cvp_pkg::cell_t c;
		cfg_shadow = '{grid_width: 128, grid_height: 128, adv_x_coef: 0, adv_y_coef: 0,
			diff_x_coef: 0, diff_y_coef: 0, lid_speed: 1048576};
		col_pos = 0;
		row_pos = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// walk the directed table, one register setting per grid
		write_all(0, 1, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
			32'h8000_0000);
		for (int i = 0; i < 9; i++)
			feed_cell(dir_tab[i].c, dir_tab[i].typed_n, dir_tab[i].r0, dir_tab[i].r1);
		drain();
		write_all(3, 4, 0, 0, 0, 0, 32'h7fff_ffff);
		for (int i = 9; i < 21; i++)
			feed_cell(dir_tab[i].c, dir_tab[i].typed_n, dir_tab[i].r0, dir_tab[i].r1);
		drain();

		// resize mid-grid: stop an 8x8 grid at row 5 col 7, shrink to 4x4 so both
		// counters fall outside and restart; the line store keeps its contents
		write_all(8, 8, $urandom_range(0, 1 << 19), $urandom_range(0, 1 << 19),
			$urandom_range(0, 1 << 19), $urandom_range(0, 1 << 19), $urandom);
		for (int i = 0; i < 5 * 8 + 7; i++) begin
			c = '{rand_val(0), rand_val(0), rand_val(0)};
			feed_cell(c);
		end
		drain();
		write_reg(cvp_pkg::REG_WIDTH, 4);
		write_reg(cvp_pkg::REG_HEIGHT, 4);
		for (int i = 0; i < 16; i++) begin
			c = '{rand_val(0), rand_val(0), rand_val(0)};
			feed_cell(c);
		end
		drain();

		// widest grid (2047 acts as 1024): one full row and three cells of the next,
		// then shrink to 3 wide so the column restarts and the 3x3 grid finishes
		write_all(2047, 3, rand_coef(), rand_coef(), rand_coef(), rand_coef(), $urandom);
		for (int i = 0; i < cvp_pkg::MAX_WIDTH + 3; i++) begin
			c = '{rand_val(i[0]), rand_val(i[1]), rand_val(i[2])};
			feed_cell(c);
		end
		drain();
		write_reg(cvp_pkg::REG_WIDTH, 3);
		for (int i = 0; i < 6; i++) begin
			c = '{rand_val(i[0]), rand_val(i[1]), rand_val(i[2])};
			feed_cell(c);
		end
		drain();

		// random grids, mostly small, with a quiet stretch in one phase
		fed = 0;
		phase = 0;
		while (fed < RANDOM_ITEMS) begin
			quiet = (phase == 3);
			case ($urandom_range(9))
				0:       w = $urandom_range(0, 2);
				1:       w = $urandom_range(11, 40);
				default: w = $urandom_range(3, 10);
			endcase
			h = ($urandom_range(9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
			write_all(w, h, rand_coef(), rand_coef(), rand_coef(), rand_coef(),
				($urandom_range(3) == 0) ? $urandom : rand_val(0));
			full = ($urandom_range(2) == 0);
			n = clampdim(cvp_pkg::DIM_W'(w), cvp_pkg::MAX_WIDTH) *
				clampdim(cvp_pkg::DIM_W'(h), cvp_pkg::MAX_HEIGHT);
			for (int i = 0; i < n; i++) begin
				c = '{rand_val(full), rand_val(full), rand_val(full)};
				feed_cell(c);
			end
			drain();
			phase++;
		end
		quiet = 1'b0;

		if (fail_cnt == 0 && pending_res.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// File: cavity_velocity_predictor_stencil.f
sv/cvp_pkg.sv
sv/cvp_ram.sv
sv/cvp_front.sv
sv/cvp_queue.sv
sv/cvp_back.sv
sv/cavity_velocity_predictor_stencil.sv
test/tb_cavity_velocity_predictor_stencil.sv
